FILE: src/complex_polar_rect_converter_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef COMPLEX_POLAR_RECT_CONVERTER_MACROS_SVH
`define COMPLEX_POLAR_RECT_CONVERTER_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CCV_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication, disabled while reset is asserted.
`define CCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/ccv_pkg.sv
package ccv_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int DATA_WIDTH    = 16;
	localparam int COMP_W        = 16;
	localparam int AW            = 32;
	// Four guard bits cover the CORDIC gain and the diagonal of the unit square.
	localparam int DW            = COMP_W + DATA_WIDTH + 4;
	localparam int ZW            = AW + 2;
	localparam int PW            = COMP_W + AW + 1;
	localparam int STAGE_W       = $clog2(CORDIC_STAGES);
	localparam int ATAN_ENTRIES  = 32;
	localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
	localparam int COMP_MAX      = 32767;
	localparam int MAG_MAX       = 65535;

	localparam logic [AW-1:0] INV_GAIN = 32'd2608131496;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ODD_NEGATE = 2'd1;

	localparam logic [AW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef logic signed [COMP_W-1:0] comp_t;

	typedef struct packed {
		logic  mode;
		logic  neg;
		comp_t a;
		comp_t b;
	} rot_side_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
		rot_side_t            side;
	} rot_t;

	typedef struct packed {
		logic  zero;
		comp_t re;
		comp_t im;
	} vec_side_t;

	typedef struct packed {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic [AW-1:0]        z;
		vec_side_t            side;
	} vec_t;

	function automatic logic [AW-1:0] stage_angle(input logic [STAGE_W-1:0] i);
		logic [ATAN_IDX_W-1:0] k;
		k = ATAN_IDX_W'(i);
		return ATAN_TAB[k];
	endfunction

endpackage

FILE: src/ccv_rot_cell.sv
module ccv_rot_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [ccv_pkg::STAGE_W-1:0]   shift,
	input  logic                          in_vld,
	input  ccv_pkg::rot_t                 in_dat,
	output logic                          out_vld,
	output ccv_pkg::rot_t                 out_dat
);
	import ccv_pkg::*;

	logic signed [DW-1:0] xi, yi, dx, dy;
	logic signed [ZW-1:0] ang;
	rot_t                 nxt;
	logic                 vld_s1;
	rot_t                 dat_s1;

	// Rotation mode: steer the residual angle toward zero.
	always_comb begin
		xi  = in_dat.x;
		yi  = in_dat.y;
		dx  = yi >>> shift;
		dy  = xi >>> shift;
		ang = $signed({{(ZW-AW){1'b0}}, stage_angle(shift)});
		nxt = in_dat;
		if (!in_dat.z[ZW-1]) begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = in_dat.z - ang;
		end else begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = in_dat.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;

endmodule

FILE: src/ccv_vec_cell.sv
module ccv_vec_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [ccv_pkg::STAGE_W-1:0]   shift,
	input  logic                          in_vld,
	input  ccv_pkg::vec_t                 in_dat,
	output logic                          out_vld,
	output ccv_pkg::vec_t                 out_dat
);
	import ccv_pkg::*;

	logic signed [DW-1:0] xi, yi, dx, dy;
	logic [AW-1:0]        ang;
	vec_t                 nxt;
	logic                 vld_s1;
	vec_t                 dat_s1;

	// Vectoring mode: drive y toward zero and accumulate the angle, modulo one turn.
	always_comb begin
		xi  = in_dat.x;
		yi  = in_dat.y;
		dx  = yi >>> shift;
		dy  = xi >>> shift;
		ang = stage_angle(shift);
		nxt = in_dat;
		if (!yi[DW-1]) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = in_dat.z + ang;
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = in_dat.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_dat = dat_s1;

endmodule

FILE: src/complex_polar_rect_converter.sv
// Throughput: one voxel per cycle while no held result stalls; each rotation and vectoring cell holds one voxel.
// A stalled result holds the whole pipeline, and input stall follows at once.
// Reset (arst_n low, asynchronous) clears all stage valid bits and both
// configuration registers to 0; datapath registers are not reset.
module complex_polar_rect_converter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            vox_valid,
	output logic                            vox_stall,
	input  logic signed [15:0]              first_value,
	input  logic signed [15:0]              second_value,
	input  logic                            slice_odd,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic [15:0]                     magnitude_out,
	output logic signed [15:0]              phase_out,
	output logic signed [15:0]              real_out,
	output logic signed [15:0]              imag_out,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ccv_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic                            cfg_data
);
	import ccv_pkg::*;

	localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd1 <<< (AW - 1));
	localparam logic signed [DW-1:0] ROUND_HALF = DW'(64'sd1 <<< (DATA_WIDTH - 1));
	localparam logic signed [DW-1:0] CMAX = DW'(COMP_MAX);
	localparam logic signed [DW-1:0] MMAX = DW'(MAG_MAX);
	localparam comp_t PH_QUARTER = comp_t'(16384);

	function automatic logic signed [DW-1:0] prescale(input comp_t v);
		logic signed [PW-1:0] p;
		p = v * $signed({1'b0, INV_GAIN});
		return DW'(p >>> (AW - DATA_WIDTH));
	endfunction

	function automatic logic signed [DW-1:0] round_lsb(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		t = v + ROUND_HALF;
		return t >>> DATA_WIDTH;
	endfunction

	function automatic comp_t sat_comp(input logic signed [DW-1:0] v);
		if (v > CMAX) begin
			return comp_t'(COMP_MAX);
		end else if (v < -CMAX) begin
			return comp_t'(-COMP_MAX);
		end
		return v[COMP_W-1:0];
	endfunction

	logic adv;
	logic input_mode_q, odd_negate_q;

	assign adv       = !(res_valid && res_stall);
	assign vox_stall = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q <= 1'b0;
			odd_negate_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_INPUT_MODE: input_mode_q <= cfg_data;
				REG_ODD_NEGATE: odd_negate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input capture with the mode and negate decision for this voxel.
	logic      vld_s1;
	rot_side_t side_s1;

	// Stage 2: prescale of the magnitude, quadrant fold of the phase.
	logic                 vld_s2, flip_s2;
	logic signed [DW-1:0] px_s2;
	logic signed [ZW-1:0] z_s2;
	rot_side_t            side_s2;
	logic signed [ZW-1:0] z_in, z_fold;
	logic                 flip;

	// Stage 3: folded start vector for the rotation chain.
	logic vld_s3;
	rot_t rot_s3;

	always_comb begin
		z_in   = $signed({{(ZW-AW){side_s1.b[COMP_W-1]}}, side_s1.b, 16'h0000});
		z_fold = z_in;
		flip   = 1'b0;
		if (side_s1.b > PH_QUARTER) begin
			flip   = 1'b1;
			z_fold = z_in - Z_HALF;
		end else if (side_s1.b < -PH_QUARTER) begin
			flip   = 1'b1;
			z_fold = z_in + Z_HALF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vox_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.mode <= input_mode_q;
			side_s1.neg  <= odd_negate_q && slice_odd;
			side_s1.a    <= first_value;
			side_s1.b    <= second_value;
			px_s2        <= prescale(side_s1.a);
			z_s2         <= z_fold;
			flip_s2      <= flip;
			side_s2      <= side_s1;
			rot_s3.x     <= flip_s2 ? -px_s2 : px_s2;
			rot_s3.y     <= '0;
			rot_s3.z     <= z_s2;
			rot_s3.side  <= side_s2;
		end
	end

	logic rot_v [CORDIC_STAGES+1];
	rot_t rot_d [CORDIC_STAGES+1];

	assign rot_v[0] = vld_s3;
	assign rot_d[0] = rot_s3;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
		ccv_rot_cell u_rot (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.shift   (STAGE_W'(g)),
			.in_vld  (rot_v[g]),
			.in_dat  (rot_d[g]),
			.out_vld (rot_v[g+1]),
			.out_dat (rot_d[g+1])
		);
	end

	// Stage 4: rectangular value after mode select and slice negation.
	logic  vld_s4;
	comp_t re_s4, im_s4;
	comp_t re_sel, im_sel;
	rot_t  rot_last;

	always_comb begin
		rot_last = rot_d[CORDIC_STAGES];
		if (rot_last.side.mode) begin
			re_sel = sat_comp(DW'(rot_last.side.a));
			im_sel = sat_comp(DW'(rot_last.side.b));
		end else begin
			re_sel = sat_comp(round_lsb(rot_last.x));
			im_sel = sat_comp(round_lsb(rot_last.y));
		end
		if (rot_last.side.neg) begin
			re_sel = -re_sel;
			im_sel = -im_sel;
		end
	end

	// Stage 5: prescale both components for the vectoring pass.
	logic                 vld_s5;
	logic signed [DW-1:0] px_s5, py_s5;
	vec_side_t            side_s5;

	// Stage 6: fold the left half plane onto the right one.
	logic vld_s6;
	vec_t vec_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= rot_v[CORDIC_STAGES];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_s4        <= re_sel;
			im_s4        <= im_sel;
			px_s5        <= prescale(re_s4);
			py_s5        <= prescale(im_s4);
			side_s5.zero <= (re_s4 == '0) && (im_s4 == '0);
			side_s5.re   <= re_s4;
			side_s5.im   <= im_s4;
			vec_s6.side  <= side_s5;
			if (side_s5.re[COMP_W-1]) begin
				vec_s6.x <= -px_s5;
				vec_s6.y <= -py_s5;
				vec_s6.z <= AW'(Z_HALF);
			end else begin
				vec_s6.x <= px_s5;
				vec_s6.y <= py_s5;
				vec_s6.z <= '0;
			end
		end
	end

	logic vec_v [CORDIC_STAGES+1];
	vec_t vec_d [CORDIC_STAGES+1];

	assign vec_v[0] = vld_s6;
	assign vec_d[0] = vec_s6;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
		ccv_vec_cell u_vec (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.shift   (STAGE_W'(g)),
			.in_vld  (vec_v[g]),
			.in_dat  (vec_d[g]),
			.out_vld (vec_v[g+1]),
			.out_dat (vec_d[g+1])
		);
	end

	// Stage 7: output register with magnitude clamp and phase rounding.
	logic                 vld_s7;
	logic [15:0]          mag_s7;
	logic signed [15:0]   ph_s7, re_s7, im_s7;
	vec_t                 vec_last;
	logic signed [DW-1:0] mag_r;
	logic [15:0]          mag_c, ph_c;
	logic [AW-1:0]        ph_sum;

	always_comb begin
		vec_last = vec_d[CORDIC_STAGES];
		mag_r    = round_lsb(vec_last.x);
		ph_sum   = vec_last.z + AW'(32'h0000_8000);
		if (mag_r[DW-1]) begin
			mag_c = '0;
		end else if (mag_r > MMAX) begin
			mag_c = 16'(MAG_MAX);
		end else begin
			mag_c = mag_r[15:0];
		end
		ph_c = ph_sum[AW-1:AW-16];
		// A zero vector has no defined angle; report zero for both.
		if (vec_last.side.zero) begin
			mag_c = '0;
			ph_c  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= vec_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s7 <= mag_c;
			ph_s7  <= $signed(ph_c);
			re_s7  <= vec_last.side.re;
			im_s7  <= vec_last.side.im;
		end
	end

	assign res_valid     = vld_s7;
	assign magnitude_out = mag_s7;
	assign phase_out     = ph_s7;
	assign real_out      = re_s7;
	assign imag_out      = im_s7;

endmodule

FILE: src/ccv_checker.sv
`include "complex_polar_rect_converter_macros.svh"

module ccv_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            vox_stall,
	input logic                            res_valid,
	input logic                            res_stall,
	input logic [15:0]                     magnitude_out,
	input logic signed [15:0]              phase_out,
	input logic signed [15:0]              real_out,
	input logic signed [15:0]              imag_out
);

	// A held result must not change while it waits for its transfer.
	`CCV_ASSERT_CLK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(magnitude_out) && $stable(phase_out) && $stable(real_out) && $stable(imag_out), "result changed while stalled")

	// The pipeline freezes on a stalled result, so the input side must stall too.
	`CCV_ASSERT_IMP(a_stall_back, res_valid && res_stall, vox_stall, "input not stalled behind a held result")

	// Components are saturated symmetrically.
	`CCV_ASSERT_IMP(a_comp_sat, res_valid, real_out != 16'sh8000 && imag_out != 16'sh8000, "component outside saturation range")

	// A zero vector reports zero magnitude and zero phase.
	`CCV_ASSERT_IMP(a_zero_vec, res_valid && real_out == 16'sd0 && imag_out == 16'sd0, magnitude_out == 16'd0 && phase_out == 16'sd0, "zero vector with nonzero polar form")

endmodule

bind complex_polar_rect_converter ccv_checker u_ccv_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import ccv_pkg::*;

	localparam int STEPS = 16;
	localparam int FRAC = 16;
	localparam longint GAIN_COMP = 64'd2608131496;
	localparam longint ARCTAN [STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
		83443, 41722, 20861
	};
	localparam int LATENCY = 2 * CORDIC_STAGES + 7;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 185;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [15:0] mag;
		comp_t       phase;
		comp_t       re;
		comp_t       im;
	} voxel_result_t;

	typedef struct packed {
		logic          mode;
		logic          negate;
		comp_t         first;
		comp_t         second;
		logic          odd;
		logic          typed;
		voxel_result_t want;
	} voxel_row_t;

	// Rows with typed set carry their expected result; the rest go through the predictor.
	localparam voxel_row_t DIRECTED [23] = '{
		// polar input
		'{0, 0, 0, 12345, 0, 1, '{0, 0, 0, 0}},
		'{0, 0, 32767, 0, 0, 0, '0},
		'{0, 0, 32767, 16384, 0, 0, '0},
		'{0, 0, 32767, -32768, 0, 0, '0},
		'{0, 0, 32767, 32767, 0, 0, '0},
		'{0, 0, 32767, -16384, 1, 0, '0},
		'{0, 0, -32767, 8192, 0, 0, '0},
		'{0, 0, 1, -1, 0, 0, '0},
		'{0, 0, 32767, 8192, 1, 0, '0},
		// polar input, odd slices negated
		'{0, 1, 20000, 1000, 1, 0, '0},
		'{0, 1, 20000, 1000, 0, 0, '0},
		'{0, 1, 0, 0, 1, 1, '{0, 0, 0, 0}},
		// rectangular input
		'{1, 0, 0, 0, 0, 1, '{0, 0, 0, 0}},
		'{1, 0, 32767, 32767, 0, 0, '0},
		'{1, 0, 0, -32768, 0, 0, '0},
		'{1, 0, -32767, 0, 1, 0, '0},
		'{1, 0, -32767, -32768, 0, 0, '0},
		'{1, 0, 1, 0, 0, 0, '0},
		'{1, 0, -1, -1, 0, 0, '0},
		'{1, 0, 0, 1, 0, 0, '0},
		// rectangular input, odd slices negated
		'{1, 1, 32767, -32768, 1, 0, '0},
		'{1, 1, -100, 0, 1, 0, '0},
		'{1, 1, 0, 0, 1, 1, '{0, 0, 0, 0}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 vox_valid = 1'b0;
	logic                 vox_stall;
	comp_t                first_value = '0;
	comp_t                second_value = '0;
	logic                 slice_odd = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic [15:0]          magnitude_out;
	comp_t                phase_out;
	comp_t                real_out;
	comp_t                imag_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_INPUT_MODE;
	logic                 cfg_data = 1'b0;

	logic rect_mode = 1'b0;
	logic negate_odd = 1'b0;
	logic sender_quiet = 1'b0;
	logic stall_quiet = 1'b0;
	int   stall_left = 0;
	int   mismatches = 0;
	int   cycle_count = 0;
	voxel_result_t voxel_results_due [$];

	complex_polar_rect_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.vox_valid(vox_valid),
		.vox_stall(vox_stall),
		.first_value(first_value),
		.second_value(second_value),
		.slice_odd(slice_odd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.magnitude_out(magnitude_out),
		.phase_out(phase_out),
		.real_out(real_out),
		.imag_out(imag_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic longint clamp_comp(input longint v);
		if (v > COMP_MAX) return COMP_MAX;
		if (v < -COMP_MAX) return -COMP_MAX;
		return v;
	endfunction

	function automatic longint round_frac(input longint v);
		return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	// Cancels the CORDIC gain and moves the value up by FRAC fraction bits.
	function automatic longint unscale(input longint v);
		return (v * GAIN_COMP) >>> (32 - FRAC);
	endfunction

	function automatic voxel_result_t convert_voxel(input comp_t a, input comp_t b,
			input logic odd);
		longint re, im, x, y, z, dx, dy;
		logic [31:0] turn;
		voxel_result_t r;
		if (rect_mode) begin
			re = clamp_comp(a);
			im = clamp_comp(b);
		end else begin
			x = unscale(a);
			y = 0;
			z = longint'(b) * 65536;
			// Fold phases beyond a quarter turn back into the CORDIC range.
			if (z > (longint'(1) <<< 30)) begin
				x = -x;
				z = z - (longint'(1) <<< 31);
			end else if (z < -(longint'(1) <<< 30)) begin
				x = -x;
				z = z + (longint'(1) <<< 31);
			end
			for (int i = 0; i < STEPS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ARCTAN[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ARCTAN[i];
				end
			end
			re = clamp_comp(round_frac(x));
			im = clamp_comp(round_frac(y));
		end
		if (negate_odd && odd) begin
			re = -re;
			im = -im;
		end
		if (re == 0 && im == 0) return '0;
		x = unscale(re);
		y = unscale(im);
		turn = '0;
		if (re < 0) begin
			x = -x;
			y = -y;
			turn = 32'h8000_0000;
		end
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				turn = turn + 32'(ARCTAN[i]);
			end else begin
				x = x - dx;
				y = y + dy;
				turn = turn - 32'(ARCTAN[i]);
			end
		end
		x = round_frac(x);
		if (x < 0) x = 0;
		if (x > MAG_MAX) x = MAG_MAX;
		turn = turn + 32'h8000;
		r.mag = x[15:0];
		r.phase = turn[31:16];
		r.re = re[15:0];
		r.im = im[15:0];
		return r;
	endfunction

	function automatic comp_t random_field(input int lowest);
		case ($urandom_range(0, 9))
			0: return comp_t'(lowest);
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			default: return comp_t'(int'($urandom_range(0, 32767 - lowest)) + lowest);
		endcase
	endfunction

	task automatic drain();
		vox_valid <= 1'b0;
		do @(posedge clk); while (voxel_results_due.size() != 0);
	endtask

	// Both registers are written back to back, only once the pipeline is empty.
	task automatic reconfigure(input logic mode, input logic negate);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_INPUT_MODE;
		cfg_data <= mode;
		do @(posedge clk); while (!cfg_ready);
		rect_mode = mode;
		cfg_index <= REG_ODD_NEGATE;
		cfg_data <= negate;
		do @(posedge clk); while (!cfg_ready);
		negate_odd = negate;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_voxel(input comp_t a, input comp_t b, input logic odd,
			input voxel_result_t want);
		int gap;
		gap = sender_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			vox_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vox_valid <= 1'b1;
		first_value <= a;
		second_value <= b;
		slice_odd <= odd;
		do @(posedge clk); while (vox_stall);
		voxel_results_due.push_back(want);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: check each transfer, then hold stall for a freshly drawn wait.
	always @(posedge clk) begin
		voxel_result_t want;
		if (res_valid && !res_stall) begin
			if (voxel_results_due.size() == 0) begin
				$error("result transfer with no voxel outstanding");
				mismatches++;
			end else begin
				want = voxel_results_due.pop_front();
				if (magnitude_out !== want.mag) begin
					$error("magnitude_out: expected %0d, got %0d", want.mag, magnitude_out);
					mismatches++;
				end
				if (phase_out !== want.phase) begin
					$error("phase_out: expected %0d, got %0d", want.phase, phase_out);
					mismatches++;
				end
				if (real_out !== want.re) begin
					$error("real_out: expected %0d, got %0d", want.re, real_out);
					mismatches++;
				end
				if (imag_out !== want.im) begin
					$error("imag_out: expected %0d, got %0d", want.im, imag_out);
					mismatches++;
				end
			end
			stall_left = stall_quiet ? 0 : $urandom_range(0, 8);
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
		end
		res_stall <= (stall_left != 0);
	end

	initial begin
		voxel_row_t row;
		voxel_result_t want;
		comp_t a;
		comp_t b;
		logic odd;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		reconfigure(1'b0, 1'b0);
		foreach (DIRECTED[k]) begin
			row = DIRECTED[k];
			if (row.mode != rect_mode || row.negate != negate_odd)
				reconfigure(row.mode, row.negate);
			want = row.typed ? row.want : convert_voxel(row.first, row.second, row.odd);
			send_voxel(row.first, row.second, row.odd, want);
		end
		for (int p = 0; p < PHASES; p++) begin
			// The first four phases walk every register setting; the rest are drawn.
			if (p < 4)
				reconfigure(p[1], p[0]);
			else
				reconfigure(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			sender_quiet = ($urandom_range(0, 3) == 0);
			stall_quiet = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				a = random_field(-32767);
				b = random_field(-32768);
				odd = 1'($urandom_range(0, 1));
				send_voxel(a, b, odd, convert_voxel(a, b, odd));
			end
		end
		drain();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/ccv_pkg.sv
src/ccv_rot_cell.sv
src/ccv_vec_cell.sv
src/complex_polar_rect_converter.sv
src/ccv_checker.sv
tb/sv/tb.sv
